/* rtl/bfa_pkg.sv */
// Shared constants and types for the best-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

    localparam int MAX_BLOCKS  = 32;
    localparam int SIZE_BITS   = 16;
    localparam int IDX_BITS    = $clog2(MAX_BLOCKS);
    localparam int CNT_BITS    = $clog2(MAX_BLOCKS + 1);
    localparam int CFG_BITS    = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int DATA_BITS   = 24;

    // Mode codes of an input word.
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    // One classified operation handed from front to back.
    typedef struct packed {
        logic                is_req;
        logic [IDX_BITS-1:0]  idx;
        logic [SIZE_BITS-1:0] size;
        logic [CNT_BITS-1:0]  count;
    } op_entry_t;

    // One allocation result.
    typedef struct packed {
        logic                granted;
        logic [IDX_BITS-1:0]  block;
        logic [SIZE_BITS-1:0] remaining;
    } result_t;

endpackage

`default_nettype wire

/* rtl/bfa_front.sv */
// Input front end: holds the scan count register and classifies input words.
`timescale 1ns / 1ps
`default_nettype none

module bfa_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bfa_pkg::CFG_BITS-1:0]  cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_mode,
    input  wire logic [bfa_pkg::IDX_BITS-1:0]  in_idx,
    input  wire logic [bfa_pkg::SIZE_BITS-1:0] in_size,
    input  wire logic                          q_full,
    output logic                               q_push,
    output bfa_pkg::op_entry_t                 q_entry
);

    logic [bfa_pkg::CFG_BITS-1:0] blocks_in_use_reg;
    logic [bfa_pkg::CNT_BITS-1:0] scan_count;
    logic                         load_in_range;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg <= '0;
        end
        else if (cfg_valid)
        begin
            blocks_in_use_reg <= cfg_data;
        end
    end

    // clamp scan count to table depth
    always_comb
    begin
        if (bfa_pkg::CNT_BITS'(blocks_in_use_reg) > bfa_pkg::CNT_BITS'(bfa_pkg::MAX_BLOCKS))
        begin
            scan_count = bfa_pkg::CNT_BITS'(bfa_pkg::MAX_BLOCKS);
        end
        else
        begin
            scan_count = bfa_pkg::CNT_BITS'(blocks_in_use_reg);
        end
    end

    assign load_in_range = bfa_pkg::CNT_BITS'(in_idx) < bfa_pkg::CNT_BITS'(bfa_pkg::MAX_BLOCKS);

    assign in_ready = !q_full;

    // out-of-range loads are accepted and dropped
    assign q_push = in_valid && in_ready &&
                    ((in_mode == bfa_pkg::MODE_REQUEST) || load_in_range);

    assign q_entry.is_req = (in_mode == bfa_pkg::MODE_REQUEST);
    assign q_entry.idx    = in_idx;
    assign q_entry.size   = in_size;
    assign q_entry.count  = scan_count;

endmodule

`default_nettype wire

/* rtl/bfa_queue.sv */
// Short operation queue between front end and scan engine.
`timescale 1ns / 1ps
`default_nettype none

module bfa_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire bfa_pkg::op_entry_t push_entry,
    output logic                    full,
    input  wire logic               pop,
    output logic                    valid,
    output bfa_pkg::op_entry_t      pop_entry
);

    bfa_pkg::op_entry_t entries_reg [bfa_pkg::QUEUE_DEPTH];

    logic [bfa_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [bfa_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [bfa_pkg::QPTR_BITS:0]   fill_reg;
    logic                          do_push;
    logic                          do_pop;

    assign full      = (fill_reg == (bfa_pkg::QPTR_BITS + 1)'(bfa_pkg::QUEUE_DEPTH));
    assign valid     = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;
    assign pop_entry = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/bfa_back.sv */
// Scan engine: free-size table, best-fit scan, write-back and output register.
`timescale 1ns / 1ps
`default_nettype none

module bfa_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire bfa_pkg::op_entry_t q_entry,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bfa_pkg::result_t        out_result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [bfa_pkg::SIZE_BITS-1:0] mem [bfa_pkg::MAX_BLOCKS];
    logic [bfa_pkg::SIZE_BITS-1:0] rd_data_reg;
    logic                          rd_en;
    logic [bfa_pkg::IDX_BITS-1:0]  rd_addr;
    logic                          wr_en;
    logic [bfa_pkg::IDX_BITS-1:0]  wr_addr;
    logic [bfa_pkg::SIZE_BITS-1:0] wr_data;

    logic [bfa_pkg::CNT_BITS-1:0]  cnt_reg,       cnt_next;
    logic [bfa_pkg::CNT_BITS-1:0]  rd_idx_reg,    rd_idx_next;
    logic [bfa_pkg::SIZE_BITS-1:0] size_reg,      size_next;
    logic                          cmp_valid_reg, cmp_valid_next;
    logic [bfa_pkg::IDX_BITS-1:0]  cmp_idx_reg,   cmp_idx_next;
    logic                          found_reg,     found_next;
    logic [bfa_pkg::IDX_BITS-1:0]  best_reg,      best_next;
    logic [bfa_pkg::SIZE_BITS-1:0] best_left_reg, best_left_next;

    logic                          out_valid_reg, out_valid_next;
    bfa_pkg::result_t              out_res_reg,   out_res_next;

    logic [bfa_pkg::SIZE_BITS-1:0] left;
    logic                          fits;

    assign fits = (rd_data_reg >= size_reg);
    assign left = rd_data_reg - size_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_idx_next    = rd_idx_reg;
        size_next      = size_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_left_next = best_left_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = rd_idx_reg[bfa_pkg::IDX_BITS-1:0];
        wr_en          = 1'b0;
        wr_addr        = q_entry.idx;
        wr_data        = q_entry.size;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_entry.is_req)
                    begin
                        cnt_next    = q_entry.count;
                        size_next   = q_entry.size;
                        rd_idx_next = '0;
                        found_next  = 1'b0;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                // issue side: one table read per cycle
                if (rd_idx_reg < cnt_reg)
                begin
                    rd_en          = 1'b1;
                    rd_idx_next    = rd_idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg[bfa_pkg::IDX_BITS-1:0];
                end
                // compare side: later index wins a tie
                if (cmp_valid_reg && fits && (!found_reg || left <= best_left_reg))
                begin
                    found_next     = 1'b1;
                    best_next      = cmp_idx_reg;
                    best_left_next = left;
                end
                if (!(rd_idx_reg < cnt_reg) && !cmp_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next.granted   = found_reg;
                    out_res_next.block     = found_reg ? best_reg : '0;
                    out_res_next.remaining = found_reg ? best_left_reg : '0;
                    wr_en      = found_reg;
                    wr_addr    = best_reg;
                    wr_data    = best_left_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        rd_idx_reg    <= rd_idx_next;
        size_reg      <= size_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_reg      <= best_next;
        best_left_reg <= best_left_next;
        out_res_reg   <= out_res_next;
    end

    // free-size table, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_res_reg;

endmodule

`default_nettype wire

/* rtl/best_fit_block_allocator_unit.sv */
// Top level of the best-fit block allocator.
//
// Usage:
//   cfg_*   : one register, the number of table entries a request scans
//             (values above the table depth scan the whole table). Write it
//             only while the block is idle; cfg_ready is always high.
//   s_axis  : input words. tuser = mode (0 load, 1 request). A load writes
//             one block size and gives no result; a request gives one word.
//   m_axis  : one result word per request: granted flag, chosen block and
//             the size left in it (block and size read 0 if not granted).
// Flow:
//   A word enters the operation queue in the cycle it is accepted and the
//   scan engine pops it once idle. A load is written to the table in the
//   cycle it is popped. A request scans N entries, N the clamped scan
//   count: one table read per cycle through the single comparator, then
//   a write-back of the chosen block in the cycle the result is loaded.
//   The queue keeps accepting up to four words while the engine is busy.
// Reset: clears the scan count to 0, the queue and the engine state. Table
//   entries are undefined until loaded.
// Stall: a result waits in the output register; the engine stops before
//   loading the next result until that one is taken, and the queue then
//   fills and drops s_axis_tready.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_block_allocator_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bfa_pkg::CFG_BITS-1:0]  cfg_data,   // blocks_in_use
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [bfa_pkg::DATA_BITS-1:0] s_axis_tdata,  // load_index, size_value
    input  wire logic                          s_axis_tuser,  // mode
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [bfa_pkg::DATA_BITS-1:0]      m_axis_tdata,  // chosen_block, remaining_size
    output logic                               m_axis_tuser   // granted
);

    localparam int SIZE_LO = bfa_pkg::IDX_BITS;
    localparam int SIZE_HI = bfa_pkg::IDX_BITS + bfa_pkg::SIZE_BITS - 1;

    logic               q_full;
    logic               q_push;
    bfa_pkg::op_entry_t q_push_entry;
    logic               q_valid;
    logic               q_pop;
    bfa_pkg::op_entry_t q_pop_entry;
    bfa_pkg::result_t   result;

    bfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_idx    (s_axis_tdata[bfa_pkg::IDX_BITS-1:0]),
        .in_size   (s_axis_tdata[SIZE_HI:SIZE_LO]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_push_entry)
    );

    // decouples word intake from the scan engine
    bfa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .pop_entry  (q_pop_entry)
    );

    bfa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_pop_entry),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // pack result word, zero padded to whole bytes
    assign m_axis_tuser = result.granted;
    assign m_axis_tdata = bfa_pkg::DATA_BITS'({result.remaining, result.block});

endmodule

`default_nettype wire
